@@ sv/ptba_pkg.sv @@
// ----------------------------------------------------------------------------
// ptba_pkg
// Shared types and constants for the per-task busy time accumulator.
// ----------------------------------------------------------------------------
package ptba_pkg;

    localparam int TASKS_DEF  = 16;
    localparam int ACTION_W   = 2;
    localparam int TASK_W     = 4;
    localparam int TASK_CODES = 2 ** TASK_W;
    localparam int STAMP_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int DEPTH_W    = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_END   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

@@ sv/ptba_req_if.sv @@
// ----------------------------------------------------------------------------
// ptba_req_if
// Request channel: event action, task index and timer value.
// ----------------------------------------------------------------------------
interface ptba_req_if;
    logic                          valid;
    logic                          ready;
    logic [ptba_pkg::ACTION_W-1:0] action;
    logic [ptba_pkg::TASK_W-1:0]   task_req;
    logic [ptba_pkg::STAMP_W-1:0]  timestamp;

    modport source (output valid, action, task_req, timestamp, input ready);
    modport sink   (input valid, action, task_req, timestamp, output ready);
endinterface

@@ sv/ptba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ptba_rsp_if
// Result channel: task total, nesting depth and ignored flag.
// ----------------------------------------------------------------------------
interface ptba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ptba_pkg::TOTAL_W-1:0] total_ticks;
    logic [ptba_pkg::DEPTH_W-1:0] nesting;
    logic                         ignored;

    modport source (output valid, total_ticks, nesting, ignored, input ready);
    modport sink   (input valid, total_ticks, nesting, ignored, output ready);
endinterface

@@ sv/ptba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptba_ctrl
// Controller: accepts one request, then commits it once the result slot frees.
// ----------------------------------------------------------------------------
module ptba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ptba_pkg::t_status i_status,
    output ptba_pkg::t_cmd    o_cmd
);

    ptba_pkg::t_state r_state;
    ptba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptba_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = ptba_pkg::ST_EXEC;
                end
            end
            ptba_pkg::ST_EXEC: begin
                if (!i_status.out_busy) begin
                    n_state = ptba_pkg::ST_IDLE;
                end
            end
            default: n_state = ptba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ptba_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ptba_pkg::ST_EXEC: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ptba_pkg::ST_EXEC)
        else $error("load did not enter exec");

    a_no_load_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.commit))
        else $error("load and commit together");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == ptba_pkg::ST_IDLE && o_ready)
        else $error("commit did not return to idle");

endmodule

@@ sv/ptba_dp.sv @@
// ----------------------------------------------------------------------------
// ptba_dp
// Datapath: per-task tables, entry read, update with saturation, result slot.
// ----------------------------------------------------------------------------
module ptba_dp #(
    parameter int TASKS = ptba_pkg::TASKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptba_pkg::t_cmd                i_cmd,
    output ptba_pkg::t_status             o_status,
    input  logic [ptba_pkg::ACTION_W-1:0] i_action,
    input  logic [ptba_pkg::TASK_W-1:0]   i_task_req,
    input  logic [ptba_pkg::STAMP_W-1:0]  i_timestamp,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptba_pkg::TOTAL_W-1:0]  o_total_ticks,
    output logic [ptba_pkg::DEPTH_W-1:0]  o_nesting,
    output logic                          o_ignored
);

    localparam int ENTRIES = (TASKS < ptba_pkg::TASK_CODES) ? TASKS : ptba_pkg::TASK_CODES;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ptba_pkg::DEPTH_W-1:0] r_depth [ENTRIES];
    logic [ptba_pkg::STAMP_W-1:0] r_stamp [ENTRIES];
    logic [ptba_pkg::TOTAL_W-1:0] r_total [ENTRIES];

    ptba_pkg::t_action            r_act;
    logic                         r_hit;
    logic [IDX_W-1:0]             r_idx;
    logic [ptba_pkg::STAMP_W-1:0] r_ts;
    logic [ptba_pkg::DEPTH_W-1:0] r_d;
    logic [ptba_pkg::STAMP_W-1:0] r_s;
    logic [ptba_pkg::TOTAL_W-1:0] r_t;

    logic                         r_out_valid;
    logic [ptba_pkg::TOTAL_W-1:0] r_out_tot;
    logic [ptba_pkg::DEPTH_W-1:0] r_out_nest;
    logic                         r_out_ign;

    logic                         hit;
    logic [IDX_W-1:0]             idx;
    logic [ptba_pkg::STAMP_W-1:0] elapsed;
    logic [ptba_pkg::TOTAL_W:0]   sum;
    logic [ptba_pkg::DEPTH_W-1:0] n_d;
    logic [ptba_pkg::STAMP_W-1:0] n_s;
    logic [ptba_pkg::TOTAL_W-1:0] n_t;
    logic                         ign;
    logic                         wr;
    logic [ptba_pkg::TOTAL_W-1:0] res_tot;
    logic [ptba_pkg::DEPTH_W-1:0] res_nest;
    logic                         res_ign;

    // entry select
    assign hit = 32'(i_task_req) < 32'(TASKS);
    assign idx = hit ? IDX_W'(i_task_req) : '0;

    // read-modify-write of the latched entry
    always_comb begin
        elapsed = r_ts - r_s;
        sum     = {1'b0, r_t} + (ptba_pkg::TOTAL_W + 1)'(elapsed);
        n_d     = r_d;
        n_s     = r_s;
        n_t     = r_t;
        ign     = 1'b0;
        wr      = 1'b0;
        case (r_act)
            ptba_pkg::ACT_START: begin
                if (r_d == ptba_pkg::DEPTH_MAX) begin
                    ign = 1'b1;
                end else begin
                    n_d = r_d + 1'b1;
                    wr  = 1'b1;
                    if (r_d == '0) begin
                        n_s = r_ts;
                    end
                end
            end
            ptba_pkg::ACT_END: begin
                if (r_d == '0) begin
                    ign = 1'b1;
                end else begin
                    n_d = r_d - 1'b1;
                    wr  = 1'b1;
                    if (r_d == ptba_pkg::DEPTH_W'(1)) begin
                        n_t = sum[ptba_pkg::TOTAL_W] ? ptba_pkg::TOTAL_MAX
                                                     : sum[ptba_pkg::TOTAL_W-1:0];
                    end
                end
            end
            default: begin
                ign = 1'b0;
            end
        endcase

        if (r_act == ptba_pkg::ACT_CLEAR) begin
            res_tot  = '0;
            res_nest = '0;
            res_ign  = 1'b0;
        end else if (!r_hit) begin
            res_tot  = '0;
            res_nest = '0;
            res_ign  = 1'b1;
        end else begin
            res_tot  = n_t;
            res_nest = n_d;
            res_ign  = ign;
        end
    end

    // task tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_depth[k] <= '0;
                r_stamp[k] <= '0;
                r_total[k] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_act == ptba_pkg::ACT_CLEAR) begin
                for (int k = 0; k < ENTRIES; k++) begin
                    r_depth[k] <= '0;
                    r_stamp[k] <= '0;
                    r_total[k] <= '0;
                end
            end else if (r_hit && wr) begin
                r_depth[r_idx] <= n_d;
                r_stamp[r_idx] <= n_s;
                r_total[r_idx] <= n_t;
            end
        end
    end

    // request latch and entry read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= ptba_pkg::t_action'(i_action);
            r_hit <= hit;
            r_idx <= idx;
            r_ts  <= i_timestamp;
            r_d   <= r_depth[idx];
            r_s   <= r_stamp[idx];
            r_t   <= r_total[idx];
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_tot  <= res_tot;
            r_out_nest <= res_nest;
            r_out_ign  <= res_ign;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid           = r_out_valid;
    assign o_total_ticks     = r_out_tot;
    assign o_nesting         = r_out_nest;
    assign o_ignored         = r_out_ign;

    a_commit_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit left result slot empty");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_act == ptba_pkg::ACT_CLEAR)
            |=> r_depth[0] == '0 && r_total[0] == '0 && o_nesting == '0 && !o_ignored)
        else $error("clear left state behind");

    a_ignored_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit && ign) |=> $stable(r_depth[r_idx]))
        else $error("ignored event changed depth");

endmodule

@@ sv/per_task_busy_time_accumulator.sv @@
// ----------------------------------------------------------------------------
// per_task_busy_time_accumulator
// Per-task busy time profiler: nesting depth, start stamp and saturating total.
// ----------------------------------------------------------------------------
// the request and its entry are latched, then the result goes to the output slot once that frees
// a new request is taken only after the previous one commits, following the table read then the
//   read-modify-write of the same entry
// a request is taken while the previous result still waits in the output slot
// reset clears every table entry and the result slot in the same cycle
// ----------------------------------------------------------------------------
module per_task_busy_time_accumulator #(
    parameter int TASKS = ptba_pkg::TASKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptba_req_if.sink   i_req,
    ptba_rsp_if.source o_rsp
);

    ptba_pkg::t_cmd    cmd;
    ptba_pkg::t_status status;

    ptba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .o_ready  (i_req.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ptba_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_req.action),
        .i_task_req    (i_req.task_req),
        .i_timestamp   (i_req.timestamp),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_total_ticks (o_rsp.total_ticks),
        .o_nesting     (o_rsp.nesting),
        .o_ignored     (o_rsp.ignored)
    );

endmodule

@@ dv/ptba_busy_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptba_busy_checker
// Watches the request and result channels of the busy time accumulator, keeps
// its own per-task depth, start stamp and total tables, works out the result
// of every accepted request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module ptba_busy_checker #(
    parameter int TASKS = ptba_pkg::TASKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ptba_req_if  i_req,
    ptba_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_accepted,
    output int   o_checked,
    output int   o_refused,
    output int   o_saturated
);

    typedef struct packed {
        logic [ptba_pkg::TOTAL_W-1:0] total;
        logic [ptba_pkg::DEPTH_W-1:0] nesting;
        logic                         ignored;
    } t_busy_report;

    logic [ptba_pkg::DEPTH_W-1:0] depth_q [TASKS];
    logic [ptba_pkg::STAMP_W-1:0] stamp_q [TASKS];
    logic [ptba_pkg::TOTAL_W-1:0] total_q [TASKS];
    t_busy_report                 awaited_reports [$];

    task automatic report_mismatch(input string what,
                                   input logic [ptba_pkg::TOTAL_W-1:0] got,
                                   input logic [ptba_pkg::TOTAL_W-1:0] want);
        if (o_errors < 40)
            $display("%0t ns ptba mismatch: %s got %0h expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    task automatic clear_busy_tables();
        for (int i = 0; i < TASKS; i++) begin
            depth_q[i] = '0;
            stamp_q[i] = '0;
            total_q[i] = '0;
        end
    endtask

    task automatic apply_busy_event(input ptba_pkg::t_action act, input int tk,
                                    input logic [ptba_pkg::STAMP_W-1:0] ts,
                                    output t_busy_report rep);
        logic [ptba_pkg::STAMP_W-1:0] elapsed;
        logic [ptba_pkg::TOTAL_W:0]   sum;
        rep = '0;
        if (act == ptba_pkg::ACT_CLEAR) begin
            clear_busy_tables();
        end else if (tk >= TASKS) begin
            rep.ignored = 1'b1;
        end else begin
            case (act)
                ptba_pkg::ACT_START: begin
                    if (depth_q[tk] == ptba_pkg::DEPTH_MAX) begin
                        rep.ignored = 1'b1;
                    end else begin
                        if (depth_q[tk] == '0)
                            stamp_q[tk] = ts;
                        depth_q[tk] = depth_q[tk] + 1'b1;
                    end
                end
                ptba_pkg::ACT_END: begin
                    if (depth_q[tk] == '0) begin
                        rep.ignored = 1'b1;
                    end else begin
                        depth_q[tk] = depth_q[tk] - 1'b1;
                        if (depth_q[tk] == '0) begin
                            elapsed     = ts - stamp_q[tk];
                            sum         = {1'b0, total_q[tk]}
                                        + (ptba_pkg::TOTAL_W + 1)'(elapsed);
                            total_q[tk] = sum[ptba_pkg::TOTAL_W] ? ptba_pkg::TOTAL_MAX
                                                                 : sum[ptba_pkg::TOTAL_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
            rep.total   = total_q[tk];
            rep.nesting = depth_q[tk];
        end
    endtask

    always @(posedge i_clk) begin
        t_busy_report seen;
        t_busy_report oldest;
        t_busy_report fresh;
        if (!i_rst_n) begin
            clear_busy_tables();
            awaited_reports.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                seen = '{total: i_rsp.total_ticks, nesting: i_rsp.nesting,
                         ignored: i_rsp.ignored};
                if (awaited_reports.size() == 0) begin
                    report_mismatch("result with no request, total_ticks", seen.total, '0);
                end else begin
                    oldest = awaited_reports.pop_front();
                    o_checked++;
                    if (oldest.ignored)
                        o_refused++;
                    if (oldest.total == ptba_pkg::TOTAL_MAX)
                        o_saturated++;
                    if (seen.total !== oldest.total)
                        report_mismatch("total_ticks", seen.total, oldest.total);
                    if (seen.nesting !== oldest.nesting)
                        report_mismatch("nesting", ptba_pkg::TOTAL_W'(seen.nesting),
                                        ptba_pkg::TOTAL_W'(oldest.nesting));
                    if (seen.ignored !== oldest.ignored)
                        report_mismatch("ignored", ptba_pkg::TOTAL_W'(seen.ignored),
                                        ptba_pkg::TOTAL_W'(oldest.ignored));
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_busy_event(ptba_pkg::t_action'(i_req.action), int'(i_req.task_req),
                                 i_req.timestamp, fresh);
                awaited_reports.push_back(fresh);
                o_accepted++;
            end
        end
        o_pending = awaited_reports.size();
    end

endmodule

@@ dv/per_task_busy_time_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_task_busy_time_accumulator_tb
// Drives task events into the busy time accumulator with random gaps on the
// request side and random stalls on the result side: directed corners (timer
// wrap, nesting, depth saturation, full-length intervals, clear), then random
// event mixes.
// ----------------------------------------------------------------------------
module per_task_busy_time_accumulator_tb;

    localparam int TASKS        = ptba_pkg::TASKS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_PAIRS   = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int SEGMENTS     = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int errors;
    int pending;
    int accepted;
    int checked;
    int refused;
    int saturated;
    int idle_cycles;
    bit send_gaps;
    bit recv_stalls;
    logic [ptba_pkg::STAMP_W-1:0] tick_now;

    always #4 i_clk = ~i_clk;

    ptba_req_if req_ch ();
    ptba_rsp_if rsp_ch ();

    per_task_busy_time_accumulator #(.TASKS(TASKS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ptba_busy_checker #(.TASKS(TASKS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_accepted  (accepted),
        .o_checked   (checked),
        .o_refused   (refused),
        .o_saturated (saturated)
    );

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic send_event(input ptba_pkg::t_action act,
                              input logic [ptba_pkg::TASK_W-1:0] tk,
                              input logic [ptba_pkg::STAMP_W-1:0] ts);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.task_req  <= tk;
        req_ch.timestamp <= ts;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall == 0 && recv_stalls && $urandom_range(0, 2) == 0)
                stall = pick_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("per_task_busy_time_accumulator_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [ptba_pkg::STAMP_W-1:0] r;
        logic [ptba_pkg::TASK_W-1:0]  tk;
        ptba_pkg::t_action            act;
        int                           w;

        req_ch.valid     <= 1'b0;
        req_ch.action    <= ptba_pkg::ACT_READ;
        req_ch.task_req  <= '0;
        req_ch.timestamp <= '0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        tick_now    = ptba_pkg::STAMP_W'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_event(ptba_pkg::ACT_READ, 4'd0, 16'h0000);
        send_event(ptba_pkg::ACT_END, 4'd3, 16'hFFFF);
        send_event(ptba_pkg::ACT_START, 4'd0, 16'hFFF0);
        send_event(ptba_pkg::ACT_END, 4'd0, 16'h0010);
        send_event(ptba_pkg::ACT_START, 4'd5, 16'd100);
        send_event(ptba_pkg::ACT_START, 4'd5, 16'd200);
        send_event(ptba_pkg::ACT_READ, 4'd5, 16'd250);
        send_event(ptba_pkg::ACT_END, 4'd5, 16'd300);
        send_event(ptba_pkg::ACT_END, 4'd5, 16'd400);
        send_event(ptba_pkg::ACT_START, 4'd15, 16'h0000);
        send_event(ptba_pkg::ACT_END, 4'd15, 16'hFFFF);
        send_event(ptba_pkg::ACT_READ, 4'd15, 16'h5A5A);
        send_event(ptba_pkg::ACT_CLEAR, 4'd15, 16'hA5A5);
        send_event(ptba_pkg::ACT_READ, 4'd15, 16'h0001);
        send_event(ptba_pkg::ACT_READ, 4'd0, 16'hFFFE);

        // nesting depth up to its ceiling and back
        for (int i = 0; i <= int'(ptba_pkg::DEPTH_MAX); i++)
            send_event(ptba_pkg::ACT_START, 4'd7, ptba_pkg::STAMP_W'($urandom));
        send_event(ptba_pkg::ACT_READ, 4'd7, ptba_pkg::STAMP_W'($urandom));
        for (int i = 0; i <= int'(ptba_pkg::DEPTH_MAX); i++)
            send_event(ptba_pkg::ACT_END, 4'd7, ptba_pkg::STAMP_W'($urandom));

        // back-to-back full-length intervals on one task
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        for (int i = 0; i < LONG_PAIRS; i++) begin
            r = ptba_pkg::STAMP_W'($urandom);
            send_event(ptba_pkg::ACT_START, 4'd9, r);
            send_event(ptba_pkg::ACT_END, 4'd9, r - 1'b1);
        end
        send_event(ptba_pkg::ACT_READ, 4'd9, 16'h0000);
        send_event(ptba_pkg::ACT_START, 4'd9, 16'h1234);
        send_event(ptba_pkg::ACT_END, 4'd9, 16'h1000);
        send_event(ptba_pkg::ACT_CLEAR, 4'd0, 16'h0000);
        send_event(ptba_pkg::ACT_READ, 4'd9, 16'hFFFF);

        // random event mixes, idling pattern changes per segment
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            send_gaps   = 1'($urandom_range(0, 1));
            recv_stalls = 1'($urandom_range(0, 1));
            repeat (RANDOM_ITEMS / SEGMENTS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_event(ptba_pkg::t_action'($urandom_range(0, 3)),
                               ptba_pkg::TASK_W'($urandom), ptba_pkg::STAMP_W'($urandom));
                end else begin
                    w   = $urandom_range(0, 99);
                    act = (w < 40) ? ptba_pkg::ACT_START : (w < 80) ? ptba_pkg::ACT_END :
                          (w < 97) ? ptba_pkg::ACT_READ : ptba_pkg::ACT_CLEAR;
                    tk  = $urandom_range(0, 1) ? ptba_pkg::TASK_W'($urandom_range(0, 3))
                                               : ptba_pkg::TASK_W'($urandom);
                    if ($urandom_range(0, 19) == 0)
                        tick_now = tick_now + ptba_pkg::STAMP_W'($urandom);
                    else
                        tick_now = tick_now + ptba_pkg::STAMP_W'($urandom_range(0, 1500));
                    send_event(act, tk, tick_now);
                end
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d requests, %0d results compared, %0d refused events", accepted,
                 checked, refused);
        $display("timer wrap, nesting to depth ceiling, full-length intervals, clears; %0d %s",
                 saturated, "results at total ceiling");
        if (errors == 0)
            $display("per_task_busy_time_accumulator_tb OK");
        else
            $display("per_task_busy_time_accumulator_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ptba_pkg.sv
sv/ptba_req_if.sv
sv/ptba_rsp_if.sv
sv/ptba_ctrl.sv
sv/ptba_dp.sv
sv/per_task_busy_time_accumulator.sv
dv/ptba_busy_checker.sv
dv/per_task_busy_time_accumulator_tb.sv
